@@ design/ssmn_pkg.sv @@
// Shared types and constants for the sparse symmetric matrix norm block.
// No dependencies; ssmn_isqrt and sparse_symmetric_matrix_norm import this package.
package ssmn_pkg;

	localparam int IDX_W   = 10;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 48;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int SIZE_W  = 11;
	localparam int CFG_W   = 11;
	localparam int CFG_IW  = 2;

	localparam logic [CFG_IW-1:0] CFG_STORAGE = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_NORM    = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SIZE    = 2'd2;

	localparam logic [1:0] STORE_GENERAL = 2'd0;
	localparam logic [1:0] STORE_UPPER   = 2'd1;
	localparam logic [1:0] STORE_LOWER   = 2'd2;

	localparam logic NORM_INF  = 1'b0;
	localparam logic NORM_FROB = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
	localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [SQ_W-1:0]   SQ_MAX     = {SQ_W{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_COL,
		S_SWEEP,
		S_DRAIN,
		S_EMIT
	} state_t;

endpackage

@@ design/ssmn_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old word when the same address is written in that cycle.
module ssmn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/ssmn_isqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle (32 steps).
// Depends on ssmn_pkg for widths.
module ssmn_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssmn_pkg::SQ_W-1:0]   value,
	output logic                        busy,
	output logic [ssmn_pkg::ROOT_W-1:0] root
);
	import ssmn_pkg::*;

	logic [SQ_W-1:0] x_q, r_q, bit_q;
	logic [SQ_W:0]   trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign busy  = (bit_q != '0);
	assign root  = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
		end else if (busy) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= value;
			r_q <= '0;
		end else if (busy) begin
			if ({1'b0, x_q} >= trial) begin
				x_q <= x_q - trial[SQ_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end
endmodule

@@ design/sparse_symmetric_matrix_norm.sv @@
// Sparse matrix infinity / Frobenius norm over a stream of nonzero entries.
// An entry stalls input through S_ROW, a mirrored one also S_COL (two row-sum updates).
// A last entry adds a sweep (S_SWEEP, S_DRAIN) that reads and zeroes the row-sum RAM,
// then the beat is presented; the Frobenius root (32 steps) runs during the sweep.
// Reset clears control at once, then a clearing pass of the RAM runs with in_stall high.
module sparse_symmetric_matrix_norm #(
	parameter int MAX_SIZE = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [ssmn_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ssmn_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ssmn_pkg::IDX_W-1:0]  column_index,
	input  logic [ssmn_pkg::IDX_W-1:0]  row_index,
	input  logic signed [ssmn_pkg::VAL_W-1:0] entry_value,
	input  logic                        last_entry,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ssmn_pkg::SUM_W-1:0]  norm_value,
	output logic                        saturated,
	output logic                        index_error
);
	import ssmn_pkg::*;

	localparam int AW  = $clog2(MAX_SIZE);
	localparam int NW  = ($clog2(MAX_SIZE + 1) > SIZE_W) ? $clog2(MAX_SIZE + 1) : SIZE_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SIZE - 1);

	// configuration
	logic [1:0]        storage_kind_q;
	logic              norm_kind_q;
	logic [SIZE_W-1:0] active_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			storage_kind_q <= STORE_GENERAL;
			norm_kind_q    <= NORM_INF;
			active_size_q  <= SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_STORAGE: storage_kind_q <= cfg_data[1:0];
				CFG_NORM:    norm_kind_q    <= cfg_data[0];
				CFG_SIZE:    active_size_q  <= cfg_data[SIZE_W-1:0];
				default:     ;
			endcase
		end
	end

	// effective size, clipped to the RAM depth
	logic [NW-1:0] n_eff;
	assign n_eff = (NW'(active_size_q) > NW'(MAX_SIZE)) ?
		NW'(MAX_SIZE) : NW'(active_size_q);

	// decode of the incoming beat
	logic [IDX_W+AW-1:0] row_ext, col_ext;
	logic [VAL_W-1:0]    mag_in;
	logic                bad_in, keep_in, sym_in, upd_in, mirror_in;

	assign row_ext = {{AW{1'b0}}, row_index};
	assign col_ext = {{AW{1'b0}}, column_index};
	assign mag_in  = entry_value[VAL_W-1] ? (~entry_value + 1'b1) : entry_value;
	assign bad_in  = ({{(NW-IDX_W){1'b0}}, column_index} >= n_eff) ||
	                 ({{(NW-IDX_W){1'b0}}, row_index} >= n_eff);
	assign sym_in  = (storage_kind_q == STORE_UPPER) || (storage_kind_q == STORE_LOWER);
	always_comb begin
		priority if (storage_kind_q == STORE_UPPER) keep_in = (row_index <= column_index);
		else if (storage_kind_q == STORE_LOWER)     keep_in = (row_index >= column_index);
		else                                        keep_in = 1'b1;
	end
	assign upd_in    = !bad_in && keep_in;
	assign mirror_in = upd_in && sym_in && (row_index != column_index);

	// state
	state_t state_q, state_d;
	logic [AW-1:0]     row_q, col_q, cnt_q, idx_s1;
	logic [VAL_W-1:0]  mag_q;
	logic [SQ_W-1:0]   sq_s1, square_sum_q;
	logic              upd_q, mirror_q, last_q, emit_q, valid_s1;
	logic              overflow_q, bad_seen_q;
	logic [SUM_W-1:0]  max_q;
	logic              out_valid_q, sat_out_q, idx_out_q;
	logic [SUM_W-1:0]  norm_out_q;

	// RAM
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [SUM_W-1:0]  ram_wdata, ram_rdata;

	ssmn_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SIZE)) u_row_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// root unit
	logic              sq_start, sq_busy;
	logic [ROOT_W-1:0] sq_root;

	assign sq_start = (state_q == S_SWEEP) && (cnt_q == '0);

	ssmn_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (square_sum_q),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// saturating adders
	logic [SUM_W:0]  row_add;
	logic [SUM_W-1:0] row_new;
	logic            row_ovf;
	logic [SQ_W-1:0] sq_amt;
	logic [SQ_W:0]   sq_add;
	logic            sq_ovf;

	assign row_add = {1'b0, ram_rdata} + {{(SUM_W+1-VAL_W){1'b0}}, mag_q};
	assign row_ovf = row_add[SUM_W];
	assign row_new = row_ovf ? SUM_MAX : row_add[SUM_W-1:0];
	assign sq_amt  = mirror_q ? (sq_s1 << 1) : sq_s1;
	assign sq_add  = {1'b0, square_sum_q} + {1'b0, sq_amt};
	assign sq_ovf  = sq_add[SQ_W];

	logic emit_go;
	assign emit_go = (state_q == S_EMIT) && !sq_busy && (!out_valid_q || !out_stall);

	// next state and RAM port selection
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = row_new;
		ram_raddr = row_ext[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_ROW;
			end
			S_ROW: begin
				ram_we    = upd_q;
				ram_raddr = col_q;
				if (mirror_q)    state_d = S_COL;
				else if (last_q) state_d = S_SWEEP;
				else             state_d = S_IDLE;
			end
			S_COL: begin
				ram_we    = 1'b1;
				ram_waddr = col_q;
				state_d   = last_q ? S_SWEEP : S_IDLE;
			end
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '0;
				ram_raddr = cnt_q;
				if (cnt_q == LAST_ADDR) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = emit_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (emit_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			cnt_q        <= '0;
			emit_q       <= 1'b0;
			valid_s1     <= 1'b0;
			overflow_q   <= 1'b0;
			bad_seen_q   <= 1'b0;
			square_sum_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == S_SWEEP);
			// count through the RAM, wrap for the next sweep
			if (state_q == S_SWEEP) begin
				cnt_q <= (cnt_q == LAST_ADDR) ? '0 : cnt_q + 1'b1;
			end
			if (state_q == S_IDLE && in_valid) begin
				emit_q <= last_entry;
				if (bad_in) bad_seen_q <= 1'b1;
			end
			if (state_q == S_ROW && upd_q) begin
				square_sum_q <= sq_ovf ? SQ_MAX : sq_add[SQ_W-1:0];
				if (row_ovf || sq_ovf) overflow_q <= 1'b1;
			end
			if (state_q == S_COL && row_ovf) overflow_q <= 1'b1;
			// hand the result to the output register and drop the matrix state
			if (emit_go) begin
				out_valid_q  <= 1'b1;
				overflow_q   <= 1'b0;
				bad_seen_q   <= 1'b0;
				square_sum_q <= '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			row_q    <= row_ext[AW-1:0];
			col_q    <= col_ext[AW-1:0];
			mag_q    <= mag_in;
			sq_s1    <= {{(SQ_W-VAL_W){1'b0}}, mag_in} * {{(SQ_W-VAL_W){1'b0}}, mag_in};
			upd_q    <= upd_in;
			mirror_q <= mirror_in;
			last_q   <= last_entry;
		end
		idx_s1 <= cnt_q;
		if (sq_start) begin
			max_q <= '0;
		end else if (valid_s1 && ({{(NW-AW){1'b0}}, idx_s1} < n_eff) && (ram_rdata > max_q)) begin
			max_q <= ram_rdata;
		end
		if (emit_go) begin
			norm_out_q <= (norm_kind_q == NORM_FROB) ?
				{{(SUM_W-ROOT_W){1'b0}}, sq_root} : max_q;
			sat_out_q  <= overflow_q;
			idx_out_q  <= bad_seen_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign norm_value  = norm_out_q;
	assign saturated   = sat_out_q;
	assign index_error = idx_out_q;

	// a new result only comes out of the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");

	// a mirrored second update never hits the row just written
	a_mirror_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COL) |-> (col_q != row_q))
		else $error("mirror update aliases its row");

	// no beat is taken while the row-sum RAM is being swept
	a_sweep_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP || state_q == S_DRAIN) |-> in_stall)
		else $error("input accepted during sweep");

	// matrix accumulators are empty right after a result is handed off
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(emit_go) |-> (square_sum_q == '0 && !overflow_q && !bad_seen_q))
		else $error("accumulators not cleared after result");
endmodule

@@ test/ssmn_norm_check.sv @@
`timescale 1ns / 100ps
// Norm predictor and result checker for sparse_symmetric_matrix_norm.
// Watches the config port and both channels; depends on ssmn_pkg.
module ssmn_norm_check
	import ssmn_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [IDX_W-1:0]        column_index,
	input  logic [IDX_W-1:0]        row_index,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic                    last_entry,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [SUM_W-1:0]        norm_value,
	input  logic                    saturated,
	input  logic                    index_error,
	output int                      fail_count,
	output int                      pending_norms
);

	typedef struct packed {
		logic [SUM_W-1:0] norm;
		logic             sat;
		logic             ierr;
	} norm_beat_t;

	norm_beat_t       norm_queue[$];
	logic [SUM_W-1:0] row_acc [1024];
	logic [SQ_W-1:0]  square_acc;
	logic             sat_seen;
	logic             ierr_seen;
	logic [1:0]       store_mode;
	logic             norm_mode;
	logic [SIZE_W-1:0] size_reg;

	assign pending_norms = norm_queue.size();

	task automatic add_row_sum(input logic [IDX_W-1:0] r, input logic [31:0] mag);
		logic [SUM_W:0] t;
		t = row_acc[r] + mag;
		if (t > SUM_MAX) begin
			t = {1'b0, SUM_MAX};
			sat_seen = 1'b1;
		end
		row_acc[r] = t[SUM_W-1:0];
	endtask

	task automatic add_square_sum(input logic [SQ_W-1:0] amount);
		logic [SQ_W:0] t;
		t = square_acc + amount;
		if (t[SQ_W]) begin
			t = {1'b0, SQ_MAX};
			sat_seen = 1'b1;
		end
		square_acc = t[SQ_W-1:0];
	endtask

	function automatic logic [ROOT_W-1:0] int_root(input logic [SQ_W-1:0] x);
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] cand;
		root = '0;
		for (int i = ROOT_W - 1; i >= 0; i--) begin
			cand = root | (32'd1 << i);
			if ({32'd0, cand} * {32'd0, cand} <= x)
				root = cand;
		end
		return root;
	endfunction

	task automatic predict_entry();
		logic [31:0]       mag;
		logic [SQ_W-1:0]   sq;
		logic [SIZE_W-1:0] n;
		logic              keep;
		norm_beat_t        beat;
		n = (size_reg > 11'd1024) ? 11'd1024 : size_reg;
		mag = entry_value[31] ? (~entry_value + 32'd1) : entry_value;
		sq = {32'd0, mag} * {32'd0, mag};
		if (column_index >= n || row_index >= n) begin
			ierr_seen = 1'b1;
		end else if (store_mode == STORE_UPPER || store_mode == STORE_LOWER) begin
			keep = (store_mode == STORE_UPPER) ? (row_index <= column_index)
			                                   : (row_index >= column_index);
			if (keep) begin
				add_row_sum(row_index, mag);
				if (row_index == column_index) begin
					add_square_sum(sq);
				end else begin
					add_row_sum(column_index, mag);
					add_square_sum(sq << 1);
				end
			end
		end else begin
			add_row_sum(row_index, mag);
			add_square_sum(sq);
		end
		if (last_entry) begin
			beat.norm = '0;
			if (norm_mode == NORM_INF) begin
				for (int i = 0; i < n; i++)
					if (row_acc[i] > beat.norm) beat.norm = row_acc[i];
			end else begin
				beat.norm = {{(SUM_W-ROOT_W){1'b0}}, int_root(square_acc)};
			end
			beat.sat = sat_seen;
			beat.ierr = ierr_seen;
			norm_queue.push_back(beat);
			foreach (row_acc[i]) row_acc[i] = '0;
			square_acc = '0;
			sat_seen = 1'b0;
			ierr_seen = 1'b0;
		end
	endtask

	task automatic note_fail(input string what, input norm_beat_t exp_b, input norm_beat_t got_b);
		if (fail_count < 10)
			$display("mismatch: %s exp norm=%h sat=%b ierr=%b got norm=%h sat=%b ierr=%b",
				what, exp_b.norm, exp_b.sat, exp_b.ierr, got_b.norm, got_b.sat, got_b.ierr);
		fail_count++;
	endtask

	always @(posedge clk) begin
		norm_beat_t got_b;
		norm_beat_t exp_b;
		if (!arst_n) begin
			foreach (row_acc[i]) row_acc[i] = '0;
			square_acc = '0;
			sat_seen = 1'b0;
			ierr_seen = 1'b0;
			store_mode = STORE_GENERAL;
			norm_mode = NORM_INF;
			size_reg = SIZE_RESET;
			norm_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_STORAGE: store_mode = cfg_data[1:0];
					CFG_NORM:    norm_mode = cfg_data[0];
					CFG_SIZE:    size_reg = cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_entry();
			if (out_valid && !out_stall) begin
				got_b = '{norm_value, saturated, index_error};
				if (norm_queue.size() == 0) begin
					note_fail("unexpected beat", '0, got_b);
				end else begin
					exp_b = norm_queue.pop_front();
					if (got_b != exp_b)
						note_fail("field", exp_b, got_b);
				end
			end
		end
	end

endmodule

@@ test/tb_sparse_symmetric_matrix_norm.sv @@
`timescale 1ns / 100ps
// Stimulus top for sparse_symmetric_matrix_norm: directed and random matrices.
// Needs ssmn_pkg, the block and ssmn_norm_check.
module tb_sparse_symmetric_matrix_norm;
	import ssmn_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IW-1:0]       cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [IDX_W-1:0]        column_index;
	logic [IDX_W-1:0]        row_index;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last_entry;
	logic                    out_valid;
	logic                    out_stall;
	logic [SUM_W-1:0]        norm_value;
	logic                    saturated;
	logic                    index_error;
	int                      fail_count;
	int                      pending_norms;
	int                      entries_sent;
	bit                      no_idle;

	// Tail wait of wait_idle, meant to cover the sweep that follows a last entry.
	localparam int DRAIN_CYCLES = 1100;

	sparse_symmetric_matrix_norm u_top (.*);

	ssmn_norm_check u_norm_check (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Receiver side: stall at random, except inside the quiet stretch.
	always @(negedge clk)
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 17);

	initial begin
		#200ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Hold the beat until the block takes it, then advance to the next falling edge.
	task automatic send_entry(input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] r,
	                          input logic [VAL_W-1:0] v, input logic l);
		while (!no_idle && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		column_index <= c;
		row_index <= r;
		entry_value <= v;
		last_entry <= l;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		@(negedge clk);
		entries_sent++;
	endtask

	// Drop valid and wait out every pending norm plus the sweep tail.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_norms != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic set_mode(input logic [1:0] st, input logic nk, input logic [CFG_W-1:0] sz);
		wait_idle();
		write_reg(CFG_STORAGE, st);
		write_reg(CFG_NORM, nk);
		write_reg(CFG_SIZE, sz);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(9))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = 32'h0000_0000;
			3, 4: begin
				v = $urandom_range(0, 32'h0004_0000);
				if ($urandom_range(1)) v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// One matrix in column order; most entries land inside the stored triangle.
	task automatic send_matrix(input int len, input logic [1:0] st, input int sz);
		int eff;
		int c;
		int r;
		eff = (sz > 1024) ? 1024 : sz;
		c = (eff > 0) ? $urandom_range(0, (eff - 1) / 2) : 0;
		for (int k = 0; k < len; k++) begin
			if (eff == 0 || $urandom_range(9) == 0) begin
				c = $urandom_range(1023);
				r = $urandom_range(1023);
			end else begin
				if (c >= eff) c = eff - 1;
				if (st == STORE_UPPER && $urandom_range(9) < 8)
					r = $urandom_range(0, c);
				else if (st == STORE_LOWER && $urandom_range(9) < 8)
					r = $urandom_range(c, eff - 1);
				else
					r = $urandom_range(0, eff - 1);
			end
			send_entry(c[IDX_W-1:0], r[IDX_W-1:0], pick_value(), k == len - 1);
			if ($urandom_range(2) == 0) c++;
		end
	endtask

	initial begin
		logic [1:0] st;
		logic       nk;
		int         sz;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_STORAGE;
		cfg_data = '0;
		in_valid = 1'b0;
		column_index = '0;
		row_index = '0;
		entry_value = '0;
		last_entry = 1'b0;
		no_idle = 1'b0;
		entries_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: general, infinity, full size; extreme indices and values.
		send_entry(10'd1023, 10'd1023, 32'h8000_0000, 1'b0);
		send_entry(10'd1023, 10'd0, 32'h7fff_ffff, 1'b0);
		send_entry(10'd0, 10'd1023, 32'hffff_ffff, 1'b1);

		// Small size: index just out of range, zero value, last entry still reports.
		set_mode(STORE_GENERAL, NORM_INF, 11'd4);
		send_entry(10'd0, 10'd3, 32'h0001_0000, 1'b0);
		send_entry(10'd4, 10'd1, 32'h0002_0000, 1'b0);
		send_entry(10'd3, 10'd3, 32'h0000_0000, 1'b1);

		// Upper stored: keep row <= col, drop below the diagonal, mirror off-diagonal.
		set_mode(STORE_UPPER, NORM_INF, 11'd8);
		send_entry(10'd2, 10'd2, 32'hfffe_0000, 1'b0);
		send_entry(10'd5, 10'd1, 32'h0003_0000, 1'b0);
		send_entry(10'd5, 10'd7, 32'h0100_0000, 1'b1);

		// Lower stored with Frobenius: two mirrored minimum values saturate the squares.
		set_mode(STORE_LOWER, NORM_FROB, 11'd1024);
		send_entry(10'd0, 10'd1023, 32'h8000_0000, 1'b0);
		send_entry(10'd1, 10'd0, 32'h1234_5678, 1'b0);
		send_entry(10'd1, 10'd512, 32'h8000_0000, 1'b1);

		// Unused storage code acts as general; oversized active size is clipped.
		set_mode(2'd3, NORM_FROB, 11'd2047);
		send_entry(10'd1023, 10'd0, 32'h7fff_ffff, 1'b0);
		send_entry(10'd1023, 10'd1023, 32'hdead_beef, 1'b1);

		// Size zero: every entry is out of range, result is zero with index_error.
		set_mode(STORE_GENERAL, NORM_INF, 11'd0);
		send_entry(10'd0, 10'd0, 32'h0001_0000, 1'b1);

		// Size one: single cell.
		set_mode(STORE_UPPER, NORM_INF, 11'd1);
		send_entry(10'd0, 10'd0, 32'h8000_0001, 1'b0);
		send_entry(10'd0, 10'd0, 32'h5555_5555, 1'b1);

		// Random phases; one stretch with no idling on either side.
		while (entries_sent < 1525) begin
			st = $urandom_range(3);
			nk = $urandom_range(1);
			case ($urandom_range(19))
				0, 1: sz = 1024;
				2:    sz = $urandom_range(1025, 2047);
				3:    sz = 0;
				4:    sz = 1;
				default: sz = $urandom_range(2, 16);
			endcase
			set_mode(st, nk, sz[CFG_W-1:0]);
			no_idle = (entries_sent > 700 && entries_sent < 900);
			repeat ($urandom_range(1, 4))
				send_matrix($urandom_range(1, 20), st, sz);
		end
		no_idle = 1'b0;

		wait_idle();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
